// ===== rtl/fcpa_pkg.sv =====
// fcpa_pkg: widths, codes and reset constants of the fixed chunk pool allocator
// no dependencies; imported by the divider and the top level
`timescale 1ns / 1ps
`default_nettype none

package fcpa_pkg;

  // field widths
  localparam int CMD_W     = 2;
  localparam int REQ_W     = 16;
  localparam int ALN_W     = 8;
  localparam int OFF_W     = 32;
  localparam int STAT_W    = 2;
  localparam int IDX_OUT_W = 10;
  localparam int COFF_W    = 22;
  localparam int CNT_W     = 11;
  localparam int LIFE_W    = 32;
  localparam int BYTES_W   = 23;
  localparam int CB_W      = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 13;

  // defaults and limits
  localparam int POOL_DEPTH_DEF = 1024;
  localparam int ALIGN_BYTES    = 16;

  localparam logic [CNT_W-1:0]   CNT_MAX         = 11'd2047;
  localparam logic [BYTES_W-1:0] BYTES_MAX       = 23'h7fffff;
  localparam logic [CNT_W-1:0]   CHUNK_COUNT_RST = 11'd1024;
  localparam logic [CB_W-1:0]    CHUNK_BYTES_RST = 13'd64;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOMEM   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/fcpa_ram.sv =====
// fcpa_ram: generic single-write, single-read ram with registered read data
// no dependencies; holds the free list links
`timescale 1ns / 1ps
`default_nettype none

module fcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/fcpa_div.sv =====
// fcpa_div: restoring divider, one quotient bit per cycle, for offset to index
// depends on fcpa_pkg; the caller guarantees the quotient fits in QW bits
`timescale 1ns / 1ps
`default_nettype none

module fcpa_div import fcpa_pkg::*; #(
  parameter int QW = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [OFF_W-1:0] dividend_i,
  input  wire logic [CB_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic                  exact_o,
  output logic      [QW-1:0]    quot_o
);

  localparam int SW  = CB_W + QW;
  localparam int CTW = $clog2(QW + 1);

  logic [OFF_W-1:0] rem_q, rem_d;
  logic [SW-1:0]    dvs_q, dvs_d;
  logic [QW-1:0]    quot_q, quot_d;
  logic [CTW-1:0]   cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [OFF_W-1:0] dvs_ext;
  logic             take;

  assign dvs_ext = OFF_W'(dvs_q);
  assign take    = (rem_q >= dvs_ext);

  // one compare and subtract per step, divisor walks right
  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      dvs_d  = SW'(divisor_i) << (QW - 1);
      quot_d = '0;
      cnt_d  = CTW'(QW);
    end else if (cnt_q != '0) begin
      if (take) begin
        rem_d = rem_q - dvs_ext;
      end
      quot_d = (quot_q << 1) | QW'(take);
      dvs_d  = dvs_q >> 1;
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CTW'(1));
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign done_o  = done_q;
  assign exact_o = (rem_q == '0);
  assign quot_o  = quot_q;

endmodule

`default_nettype wire

// ===== rtl/fixed_chunk_pool_allocator.sv =====
// Fixed chunk pool allocator. A command is taken when start_i is high and busy_o is low;
// its single result appears on the result ports for one cycle with done_o high and must
// be taken in that cycle, the receiver cannot stall it. Allocate goes from acceptance
// through decode, link ram read and update to the result. Free goes through decode, a
// range check and the one-bit-per-cycle offset divider before the chunk is pushed; a
// misaligned offset is only seen once the division ends and takes as long, while an
// offset past the pool is turned away by the range check, before any division. Pool
// reset, unknown commands and rejected allocations are answered in the decode step.
// After reset the block is busy while it writes the end marker of chunk 0. A new command
// can be taken in the cycle that shows the previous result. Double frees are not detected.
// depends on fcpa_pkg, fcpa_ram, fcpa_div
`timescale 1ns / 1ps
`default_nettype none

module fixed_chunk_pool_allocator import fcpa_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [CMD_W-1:0]     cmd_i,
  input  wire logic [REQ_W-1:0]     request_bytes_i,
  input  wire logic [ALN_W-1:0]     request_alignment_i,
  input  wire logic [OFF_W-1:0]     release_offset_i,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  output logic                      done_o,
  output logic      [STAT_W-1:0]    status_o,
  output logic      [IDX_OUT_W-1:0] chunk_index_o,
  output logic      [COFF_W-1:0]    chunk_offset_o,
  output logic      [CNT_W-1:0]     free_chunks_o,
  output logic      [CNT_W-1:0]     live_allocations_o,
  output logic      [LIFE_W-1:0]    lifetime_allocations_o,
  output logic      [BYTES_W-1:0]   bytes_in_use_o
);

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int LNK_W = IDX_W + 1;
  localparam int PRD_W = CNT_W + CB_W;
  localparam int CPW   = IDX_W + CB_W;
  localparam logic [CNT_W-1:0] FREE_RST =
    (int'(CHUNK_COUNT_RST) < POOL_DEPTH) ? CHUNK_COUNT_RST : CNT_W'(POOL_DEPTH);

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_DECODE = 6'b000100,
    ST_RD     = 6'b001000,
    ST_FCHK   = 6'b010000,
    ST_FDIV   = 6'b100000
  } fcpa_state_e;

  fcpa_state_e state_q, state_d;

  // latched command
  logic [CMD_W-1:0] cmd_q, cmd_d;
  logic [REQ_W-1:0] req_q, req_d;
  logic [ALN_W-1:0] align_q, align_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [PRD_W-1:0] prod_q, prod_d;

  // configuration
  logic [CNT_W-1:0] chunk_count_q;
  logic [CB_W-1:0]  chunk_bytes_q;

  // pool state
  logic [IDX_W-1:0]   head_q, head_d;
  logic               head_end_q, head_end_d;
  logic [CNT_W-1:0]   free_total_q, free_total_d;
  logic [CNT_W-1:0]   frontier_q, frontier_d;
  logic [CNT_W-1:0]   live_q, live_d;
  logic [LIFE_W-1:0]  life_q, life_d;
  logic [BYTES_W-1:0] used_q, used_d;

  // result registers
  logic                 done_q;
  logic [STAT_W-1:0]    status_q, status_d;
  logic [IDX_OUT_W-1:0] idx_q, idx_d;
  logic [COFF_W-1:0]    coff_q, coff_d;

  // link ram port
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr;
  logic [LNK_W-1:0] mem_wdata, mem_rdata;

  // divider port
  logic             div_start, div_done, div_exact;
  logic [IDX_W-1:0] div_quot;

  // helpers
  logic [CNT_W-1:0]   eff_cnt;
  logic               alloc_bad;
  logic [CNT_W-1:0]   fr_inc;
  logic [31:0]        fr_ext;
  logic [31:0]        head_ext;
  logic [CPW-1:0]     coff_prod;
  logic [31:0]        coff_ext;
  logic [BYTES_W:0]   used_add;
  logic [BYTES_W-1:0] cb_ext;
  logic               finish;
  logic [STAT_W-1:0]  res_status;
  logic [IDX_OUT_W-1:0] res_idx;
  logic [COFF_W-1:0]  res_coff;

  assign eff_cnt = (32'(chunk_count_q) < 32'(POOL_DEPTH)) ? chunk_count_q
                                                          : CNT_W'(POOL_DEPTH);
  assign alloc_bad = (req_q == '0)
                  || (32'(align_q) > 32'(ALIGN_BYTES))
                  || (req_q > REQ_W'(chunk_bytes_q));
  assign fr_inc    = frontier_q + 1'b1;
  assign fr_ext    = 32'(fr_inc);
  assign head_ext  = 32'(head_q);
  assign coff_prod = CPW'(head_q) * CPW'(chunk_bytes_q);
  assign coff_ext  = 32'(coff_prod);
  assign cb_ext    = BYTES_W'(chunk_bytes_q);
  assign used_add  = {1'b0, used_q} + {1'b0, cb_ext};

  // link ram: entry is {end-of-list, successor}
  fcpa_ram #(
    .WIDTH (LNK_W),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (mem_rdata)
  );

  // offset to chunk index
  fcpa_div #(
    .QW (IDX_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (off_q),
    .divisor_i  (chunk_bytes_q),
    .done_o     (div_done),
    .exact_o    (div_exact),
    .quot_o     (div_quot)
  );

  // command sequencer; one command at a time, so ram read and write never overlap
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    req_d        = req_q;
    align_d      = align_q;
    off_d        = off_q;
    prod_d       = prod_q;
    head_d       = head_q;
    head_end_d   = head_end_q;
    free_total_d = free_total_q;
    frontier_d   = frontier_q;
    live_d       = live_q;
    life_d       = life_q;
    used_d       = used_q;
    status_d     = status_q;
    idx_d        = idx_q;
    coff_d       = coff_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    div_start    = 1'b0;
    finish       = 1'b0;
    res_status   = STAT_OK;
    res_idx      = '0;
    res_coff     = '0;

    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, {IDX_W{1'b0}}};
        state_d   = ST_IDLE;
      end

      ST_IDLE: begin
        if (start_i) begin
          cmd_d   = cmd_i;
          req_d   = request_bytes_i;
          align_d = request_alignment_i;
          off_d   = release_offset_i;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        case (cmd_q)
          CMD_ALLOC: begin
            if (alloc_bad) begin
              finish     = 1'b1;
              res_status = STAT_INVALID;
            end else if ((free_total_q == '0) || head_end_q) begin
              finish     = 1'b1;
              res_status = STAT_NOMEM;
            end else begin
              mem_re  = 1'b1;
              state_d = ST_RD;
            end
          end
          CMD_FREE: begin
            prod_d  = PRD_W'(eff_cnt) * PRD_W'(chunk_bytes_q);
            state_d = ST_FCHK;
          end
          CMD_CLEAR: begin
            head_d       = '0;
            head_end_d   = 1'b0;
            free_total_d = eff_cnt;
            frontier_d   = '0;
            live_d       = '0;
            life_d       = '0;
            used_d       = '0;
            mem_we       = 1'b1;
            mem_wdata    = {1'b1, {IDX_W{1'b0}}};
            finish       = 1'b1;
          end
          default: begin
            finish     = 1'b1;
            res_status = STAT_INVALID;
          end
        endcase
      end

      // head link is in; pop the head, thread a fresh chunk when the list ends
      ST_RD: begin
        if (mem_rdata[IDX_W]) begin
          if (frontier_q >= eff_cnt) begin
            head_d     = '0;
            head_end_d = 1'b1;
          end else begin
            frontier_d = fr_inc;
            if (fr_inc < eff_cnt) begin
              head_d     = fr_ext[IDX_W-1:0];
              head_end_d = 1'b0;
              mem_we     = 1'b1;
              mem_waddr  = fr_ext[IDX_W-1:0];
              mem_wdata  = {1'b1, {IDX_W{1'b0}}};
            end else begin
              head_d     = '0;
              head_end_d = 1'b1;
            end
          end
        end else begin
          head_d     = mem_rdata[IDX_W-1:0];
          head_end_d = 1'b0;
        end
        free_total_d = free_total_q - 1'b1;
        used_d       = (used_add > {1'b0, BYTES_MAX}) ? BYTES_MAX : used_add[BYTES_W-1:0];
        life_d       = life_q + 1'b1;
        if (live_q < CNT_MAX) begin
          live_d = live_q + 1'b1;
        end
        finish   = 1'b1;
        res_idx  = head_ext[IDX_OUT_W-1:0];
        res_coff = coff_ext[COFF_W-1:0];
      end

      // range check covers a zero chunk size and keeps the quotient in IDX_W bits
      ST_FCHK: begin
        if (off_q >= OFF_W'(prod_q)) begin
          finish     = 1'b1;
          res_status = STAT_INVALID;
        end else begin
          div_start = 1'b1;
          state_d   = ST_FDIV;
        end
      end

      // push the freed chunk onto the list head, or reject a misaligned offset
      ST_FDIV: begin
        if (div_done) begin
          finish = 1'b1;
          if (!div_exact) begin
            res_status = STAT_INVALID;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = div_quot;
            mem_wdata  = {head_end_q, head_q};
            head_d     = div_quot;
            head_end_d = 1'b0;
            if (free_total_q < CNT_MAX) begin
              free_total_d = free_total_q + 1'b1;
            end
            used_d = (used_q > cb_ext) ? (used_q - cb_ext) : '0;
            if (live_q != '0) begin
              live_d = live_q - 1'b1;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish) begin
      state_d  = ST_IDLE;
      status_d = res_status;
      idx_d    = res_idx;
      coff_d   = res_coff;
    end
  end

  // control and pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      head_q       <= '0;
      head_end_q   <= 1'b0;
      free_total_q <= FREE_RST;
      frontier_q   <= '0;
      live_q       <= '0;
      life_q       <= '0;
      used_q       <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      head_end_q   <= head_end_d;
      free_total_q <= free_total_d;
      frontier_q   <= frontier_d;
      live_q       <= live_d;
      life_q       <= life_d;
      used_q       <= used_d;
      done_q       <= finish;
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    req_q    <= req_d;
    align_q  <= align_d;
    off_q    <= off_d;
    prod_q   <= prod_d;
    status_q <= status_d;
    idx_q    <= idx_d;
    coff_q   <= coff_d;
  end

  // configuration transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_count_q <= CHUNK_COUNT_RST;
      chunk_bytes_q <= CHUNK_BYTES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CHUNK_COUNT: chunk_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_CHUNK_BYTES: chunk_bytes_q <= cfg_data_i[CB_W-1:0];
        default: begin
          chunk_count_q <= chunk_count_q;
        end
      endcase
    end
  end

  assign cfg_ready_o            = 1'b1;
  assign busy_o                 = (state_q != ST_IDLE);
  assign done_o                 = done_q;
  assign status_o               = status_q;
  assign chunk_index_o          = idx_q;
  assign chunk_offset_o         = coff_q;
  assign free_chunks_o          = free_total_q;
  assign live_allocations_o     = live_q;
  assign lifetime_allocations_o = life_q;
  assign bytes_in_use_o         = used_q;

endmodule

`default_nettype wire
